// ----- sv/ikgc_pkg.sv -----
// ----------------------------------------------------------------------------
// ikgc_pkg
// shared constants and helpers of the integer kernel gaussian convolution unit
// ----------------------------------------------------------------------------
package ikgc_pkg;

	localparam int KSIZE      = 5;
	localparam int PAD        = KSIZE / 2;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COEF_BITS  = 12;
	localparam int COEF_ROWS  = 5;
	localparam int ROW_BITS   = COEF_ROWS * COEF_BITS;
	localparam int PIX_BITS   = 8;

	localparam int COL_W      = 11;                    // image_width register
	localparam int ROW_W      = 13;                    // image_height register
	localparam int CFG_IDX_W  = 3;
	localparam int KIDX_W     = $clog2(KSIZE);
	localparam int SLOT_W     = $clog2(KSIZE);
	localparam int MCOL_W     = $clog2(MAX_WIDTH);
	localparam int MEM_DEPTH  = KSIZE * MAX_WIDTH;
	localparam int MEM_AW     = SLOT_W + MCOL_W;
	localparam int TOT_W      = $clog2(KSIZE * KSIZE * ((1 << COEF_BITS) - 1) + 1);
	localparam int PROD_W     = PIX_BITS + COEF_BITS;
	localparam int ACC_W      = $clog2(KSIZE * KSIZE * 255 * ((1 << COEF_BITS) - 1) + 1);
	localparam int DCNT_W     = $clog2(ACC_W);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF4  = 3'd6;

	// sum of the used coefficients of one kernel row
	function automatic logic [TOT_W-1:0] row_sum(input logic [ROW_BITS-1:0] row);
		logic [TOT_W-1:0] s;
		s = '0;
		for (int k = 0; k < KSIZE; k++) begin
			s = s + TOT_W'(row[k*COEF_BITS +: COEF_BITS]);
		end
		return s;
	endfunction

endpackage

// ----- sv/ikgc_ram.sv -----
// ----------------------------------------------------------------------------
// ikgc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ikgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/integer_kernel_gaussian_convolution_unit.sv -----
// ----------------------------------------------------------------------------
// integer_kernel_gaussian_convolution_unit
// 5x5 integer kernel convolution over a raster stream, replicated borders,
// exact division by the kernel total with round half to even
// ----------------------------------------------------------------------------
//
// channel   direction  payload                                   transfer
// s_axis    in         tdata: pixel_in, tuser: kind             tvalid & tready
// m_axis    out        tdata: pixel_out, tlast: run_last,       tvalid & tready
//                      tuser: frame_end
// cfg       in         cfg_index: register, cfg_data: value      cfg_valid & cfg_ready
//
// sequence: one input transfer at a time; each result takes 25 line store reads
//   through a shared multiply-accumulate, a 25-step restoring divider,
//   rounding and bookkeeping in S_ADV and S_NEXT, then waits on m_axis
// an input that releases nothing returns to idle directly or through S_CHECK
// reset: all counters zero, kernel total zero, geometry 1024 x 1024; the line
//   store is not cleared
// stalls: a held result blocks the next input until it is taken
//
module integer_kernel_gaussian_convolution_unit
	import ikgc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] pixel_in
	input  logic                 s_axis_tuser,   // [0] kind
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,   // [7:0] pixel_out
	output logic                 m_axis_tlast,
	output logic                 m_axis_tuser,   // [0] frame_end
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_BITS-1:0]  cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_MAC   = 8'b0000_0100,
		S_FLUSH = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_ADV   = 8'b0010_0000,
		S_NEXT  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [COL_W-1:0]    width_q;
	logic [ROW_W-1:0]    height_q;
	logic [ROW_BITS-1:0] coef_row_q [COEF_ROWS];
	logic [TOT_W-1:0]    total_q;

	// stream position
	logic [ROW_W-1:0]  in_row_q, out_row_q, ir_q;
	logic [COL_W-1:0]  in_col_q, out_col_q, ic_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;

	// step bookkeeping
	logic       drain_q, more_q, last_q, fe_q, fe_step_q;
	logic [1:0] n_q;

	// multiply-accumulate
	logic [KIDX_W-1:0]    j_q, i_q;
	logic                 v_s1, v_s2;
	logic [COEF_BITS-1:0] coef_s1;
	logic [PROD_W-1:0]    prod_s2;
	logic [ACC_W-1:0]     acc_q;
	logic [PIX_BITS-1:0]  ram_rdata;

	// divider
	logic [ACC_W-1:0]  quo_q;
	logic [TOT_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [PIX_BITS-1:0] pix_q;

	assign cfg_ready = 1'b1;

	// effective geometry
	logic [COL_W-1:0] w_c;
	logic [ROW_W-1:0] h_c;

	always_comb begin
		if (width_q == '0) begin
			w_c = COL_W'(1);
		end else if (width_q > COL_W'(MAX_WIDTH)) begin
			w_c = COL_W'(MAX_WIDTH);
		end else begin
			w_c = width_q;
		end
		if (height_q == '0) begin
			h_c = ROW_W'(1);
		end else if (height_q > ROW_W'(MAX_HEIGHT)) begin
			h_c = ROW_W'(MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
	end

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(KSIZE - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	// input side: where the accepted pixel lands
	logic              in_acc, wrap_c, ok_c;
	logic [ROW_W-1:0]  ir_c;
	logic [COL_W-1:0]  ic_c, ic_inc_c;
	logic [SLOT_W-1:0] ir_slot_c;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		wrap_c    = (in_col_q >= w_c);
		ir_c      = wrap_c ? in_row_q + ROW_W'(1) : in_row_q;
		ir_slot_c = wrap_c ? slot_inc(in_slot_q) : in_slot_q;
		ic_c      = wrap_c ? '0 : in_col_q;
		ic_inc_c  = ic_c + COL_W'(1);
		ok_c      = (in_row_q < h_c) && (ir_c < h_c);
	end

	logic pix_wr;
	assign pix_wr = in_acc && !s_axis_tuser && ok_c;

	// next output ready to be released by the rows seen so far
	logic [ROW_W:0]   rr_o;
	logic [COL_W:0]   cc_o, ccl_o;
	logic             cond_c;
	logic             frame_done_c;

	always_comb begin
		rr_o  = {1'b0, out_row_q} + (ROW_W + 1)'(PAD);
		cc_o  = {1'b0, out_col_q} + (COL_W + 1)'(PAD);
		ccl_o = (cc_o > {1'b0, w_c - COL_W'(1)}) ? {1'b0, w_c - COL_W'(1)} : cc_o;
		cond_c = (out_row_q < h_c) && (rr_o <= {1'b0, h_c - ROW_W'(1)}) &&
			((rr_o < {1'b0, ir_q}) || ((rr_o == {1'b0, ir_q}) && (ccl_o <= {1'b0, ic_q})));
		frame_done_c = (in_row_q >= h_c) && (out_row_q >= h_c);
	end

	// window address of tap (j,i) around the current output
	logic [COL_W-1:0]  c_eff;
	logic [ROW_W+1:0]  rsum;
	logic [COL_W+1:0]  csum;
	logic [ROW_W-1:0]  rr_m;
	logic [COL_W-1:0]  cc_m;
	logic [3:0]        t4, t4a, t4b;
	logic [SLOT_W-1:0] slot_m;
	logic [MEM_AW-1:0] raddr;
	logic [ROW_BITS-1:0] row_sel;
	logic [COEF_BITS-1:0] coef_c;

	always_comb begin
		c_eff = (out_col_q >= w_c) ? w_c - COL_W'(1) : out_col_q;
		rsum  = {2'b00, out_row_q} + (ROW_W + 2)'(j_q);
		csum  = {2'b00, c_eff} + (COL_W + 2)'(i_q);
		rr_m  = (rsum < (ROW_W + 2)'(PAD)) ? '0 : ROW_W'(rsum - (ROW_W + 2)'(PAD));
		if (rsum >= (ROW_W + 2)'(PAD) && (rsum - (ROW_W + 2)'(PAD)) >= {2'b00, h_c}) begin
			rr_m = h_c - ROW_W'(1);
		end
		cc_m  = (csum < (COL_W + 2)'(PAD)) ? '0 : COL_W'(csum - (COL_W + 2)'(PAD));
		if (csum >= (COL_W + 2)'(PAD) && (csum - (COL_W + 2)'(PAD)) >= {2'b00, w_c}) begin
			cc_m = w_c - COL_W'(1);
		end
		// ring slot of the clamped row, relative to the output row's slot
		t4  = 4'(out_slot_q) + 4'(KSIZE) + 4'(rr_m) - 4'(out_row_q);
		t4a = (t4 >= 4'(KSIZE)) ? t4 - 4'(KSIZE) : t4;
		t4b = (t4a >= 4'(KSIZE)) ? t4a - 4'(KSIZE) : t4a;
		slot_m  = SLOT_W'(t4b);
		raddr   = {slot_m, cc_m[MCOL_W-1:0]};
		row_sel = coef_row_q[j_q];
		coef_c  = row_sel[i_q*COEF_BITS +: COEF_BITS];
	end

	ikgc_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(MEM_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (pix_wr),
		.waddr({ir_slot_c, ic_c[MCOL_W-1:0]}),
		.wdata(s_axis_tdata),
		.re   (state_q == S_MAC),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// rounding of the finished quotient
	logic [TOT_W:0]     rem2;
	logic               up;
	logic [ACC_W:0]     q1;
	logic [PIX_BITS-1:0] pix_c;
	logic [TOT_W+1:0]   r2;
	logic               ge;

	always_comb begin
		rem2 = {rem_q, 1'b0};
		up   = (rem2 > {1'b0, total_q}) || ((rem2 == {1'b0, total_q}) && quo_q[0]);
		q1   = {1'b0, quo_q} + (ACC_W + 1)'(up);
		if (total_q == '0) begin
			pix_c = '0;
		end else if (q1 > (ACC_W + 1)'(255)) begin
			pix_c = 8'hFF;
		end else begin
			pix_c = q1[PIX_BITS-1:0];
		end
		r2 = {1'b0, rem_q, quo_q[ACC_W-1]};
		ge = (r2 >= {2'b00, total_q});
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (!s_axis_tuser) begin
						if (ok_c) begin
							state_d = S_CHECK;
						end
					end else if ((in_row_q >= h_c) && (out_row_q < h_c)) begin
						state_d = S_MAC;
					end
				end
			end
			S_CHECK: state_d = cond_c ? S_MAC : S_IDLE;
			S_MAC: begin
				if ((j_q == KIDX_W'(KSIZE - 1)) && (i_q == KIDX_W'(KSIZE - 1))) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!v_s1 && !v_s2) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (dcnt_q == DCNT_W'(ACC_W - 1)) begin
					state_d = S_ADV;
				end
			end
			S_ADV:  state_d = S_NEXT;
			S_NEXT: state_d = S_OUT;
			S_OUT: begin
				if (m_axis_tready) begin
					state_d = more_q ? S_MAC : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			width_q    <= COL_W'(1024);
			height_q   <= ROW_W'(1024);
			for (int k = 0; k < COEF_ROWS; k++) begin
				coef_row_q[k] <= '0;
			end
			total_q    <= '0;
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			drain_q    <= 1'b0;
			more_q     <= 1'b0;
			n_q        <= '0;
			j_q        <= '0;
			i_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_MAC);
			v_s2    <= v_s1;

			// register writes, kernel total kept up to date row by row
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[COL_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
					default: begin
						if (cfg_index >= REG_COEF0 && cfg_index <= REG_COEF4) begin
							coef_row_q[KIDX_W'(cfg_index - REG_COEF0)] <= cfg_data;
							total_q <= total_q
								- row_sum(coef_row_q[KIDX_W'(cfg_index - REG_COEF0)])
								+ row_sum(cfg_data);
						end
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						n_q     <= '0;
						drain_q <= s_axis_tuser;
						if (!s_axis_tuser) begin
							if (ok_c) begin
								if (ic_inc_c >= w_c) begin
									in_col_q  <= '0;
									in_row_q  <= ir_c + ROW_W'(1);
									in_slot_q <= slot_inc(ir_slot_c);
								end else begin
									in_col_q  <= ic_inc_c;
									in_row_q  <= ir_c;
									in_slot_q <= ir_slot_c;
								end
							end else if ((in_row_q < h_c) && wrap_c) begin
								// row end seen late, next row is past the frame
								in_col_q  <= '0;
								in_row_q  <= ir_c;
								in_slot_q <= ir_slot_c;
							end
						end else if (frame_done_c) begin
							in_row_q   <= '0;
							in_col_q   <= '0;
							in_slot_q  <= '0;
							out_row_q  <= '0;
							out_col_q  <= '0;
							out_slot_q <= '0;
						end
					end
				end
				S_CHECK: begin
					if (!cond_c && frame_done_c) begin
						in_row_q   <= '0;
						in_col_q   <= '0;
						in_slot_q  <= '0;
						out_row_q  <= '0;
						out_col_q  <= '0;
						out_slot_q <= '0;
					end
				end
				S_MAC: begin
					if (i_q == KIDX_W'(KSIZE - 1)) begin
						i_q <= '0;
						j_q <= (j_q == KIDX_W'(KSIZE - 1)) ? '0 : j_q + KIDX_W'(1);
					end else begin
						i_q <= i_q + KIDX_W'(1);
					end
				end
				S_FLUSH: dcnt_q <= '0;
				S_DIV:   dcnt_q <= dcnt_q + DCNT_W'(1);
				S_ADV: begin
					n_q <= n_q + 2'd1;
					if (out_col_q + COL_W'(1) >= w_c) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + ROW_W'(1);
						out_slot_q <= slot_inc(out_slot_q);
					end else begin
						out_col_q  <= out_col_q + COL_W'(1);
					end
				end
				S_NEXT: more_q <= !drain_q && (n_q < 2'(PAD + 1)) && cond_c;
				S_OUT: begin
					if (m_axis_tready && !more_q && (fe_step_q || frame_done_c)) begin
						in_row_q   <= '0;
						in_col_q   <= '0;
						in_slot_q  <= '0;
						out_row_q  <= '0;
						out_col_q  <= '0;
						out_slot_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pix_wr) begin
			ir_q <= ir_c;
			ic_q <= ic_c;
		end
		coef_s1 <= coef_c;
		prod_s2 <= PROD_W'(ram_rdata) * PROD_W'(coef_s1);
		if (state_d == S_MAC && state_q != S_MAC) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (state_q == S_FLUSH) begin
			quo_q <= acc_q;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			rem_q <= ge ? TOT_W'(r2 - {2'b00, total_q}) : TOT_W'(r2);
			quo_q <= {quo_q[ACC_W-2:0], ge};
		end
		if (state_q == S_ADV) begin
			pix_q     <= pix_c;
			fe_q      <= (out_row_q == h_c - ROW_W'(1)) && (out_col_q == w_c - COL_W'(1));
			fe_step_q <= drain_q &&
				(out_row_q == h_c - ROW_W'(1)) && (out_col_q == w_c - COL_W'(1));
		end
		if (state_q == S_NEXT) begin
			last_q <= !(!drain_q && (n_q < 2'(PAD + 1)) && cond_c);
		end
	end

	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = pix_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = fe_q;

	// checks
	a_wr_only_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		pix_wr |-> (s_axis_tvalid && s_axis_tready && !s_axis_tuser))
		else $error("line store written without an input transfer");

	a_mac_pipe_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == S_MAC || state_q == S_FLUSH))
		else $error("accumulator fed outside the window pass");

	a_slots_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_slot_q < SLOT_W'(KSIZE)) && (out_slot_q < SLOT_W'(KSIZE)))
		else $error("line ring slot out of range");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("frame end not on the last result of its input");

	a_div_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_DIV) |-> $past(state_q == S_FLUSH))
		else $error("divider started before the accumulator settled");

endmodule
